// File: src/vertex_rotate_project_divide_top_macros.svh
// assertion macros shared by the vertex transform modules
`ifndef VERTEX_ROTATE_PROJECT_DIVIDE_TOP_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_DIVIDE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define VRPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VRPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/vrpd_pkg.sv
// types and constants of the vertex rotate, project and divide block
package vrpd_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int RotW        = 16;
  localparam int ProdW       = COORD_WIDTH + RotW;
  localparam int NumW        = COORD_WIDTH + 17;
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);

  typedef enum logic [2:0] {
    CFG_ROT_COS      = 3'd0,
    CFG_ROT_SIN      = 3'd1,
    CFG_DEPTH_OFFSET = 3'd2,
    CFG_PROJ_SCALE_X = 3'd3,
    CFG_PROJ_SCALE_Y = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic                          last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic signed [COORD_WIDTH-1:0] depth;
    logic                          depth_invalid;
    logic                          last_out;
  } screen_t;

  typedef struct packed {
    logic signed [RotW-1:0]        rot_cos;
    logic signed [RotW-1:0]        rot_sin;
    logic signed [COORD_WIDTH-1:0] depth_offset;
    logic [RotW-1:0]               proj_scale_x;
    logic [RotW-1:0]               proj_scale_y;
  } cfg_t;

  // one projected vertex waiting for division
  typedef struct packed {
    logic signed [NumW-1:0]        num_x;
    logic signed [NumW-1:0]        num_y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          bad;
    logic                          last;
  } proj_t;

  localparam logic [RotW-1:0]        RstRotCos  = RotW'(11785);
  localparam logic [RotW-1:0]        RstRotSin  = RotW'(-11382);
  localparam logic [COORD_WIDTH-1:0] RstDepthOf = COORD_WIDTH'(2031616);
  localparam logic [RotW-1:0]        RstScale   = RotW'(16397);

endpackage

// File: src/vertex_rotate_project_divide_top.sv
// top level of the vertex rotate, project and divide block
// usage
//   input channel in_valid_i / in_ready_o / in_i carries one model-space vertex
//   per transaction (q8.16 x, y, z and a last-vertex marker)
//   output channel out_valid_o / out_ready_i / out_o returns one screen-space
//   result per vertex, in order: screen x, screen y, depth, invalid flag, marker
//   configuration channel cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i
//   writes rot_cos (0), rot_sin (1), depth_offset (2), proj_scale_x (3),
//   proj_scale_y (4); it is always ready, unknown indexes are dropped
// throughput: one vertex per cycle, sustained while out_ready_i stays high
// pipeline: 8 front stages for three rotations, offset and projection products,
//   the queue, one prep stage, COORD_WIDTH division stages producing one
//   quotient bit each, and the output register
// stall: while out_valid_o is high and out_ready_i is low the divider pipeline holds; the front keeps
//   accepting until the 4-entry queue fills, then in_ready_o drops
// reset: pipelines and queue empty, registers return to their default view
module vertex_rotate_project_divide_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vrpd_pkg::vertex_t     in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output vrpd_pkg::screen_t     out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [vrpd_pkg::COORD_WIDTH-1:0] cfg_data_i
);

`include "vertex_rotate_project_divide_top_macros.svh"

  localparam int RW = vrpd_pkg::RotW;

  vrpd_pkg::cfg_t  cfg_q;
  logic            push, q_full, pop, q_valid;
  vrpd_pkg::proj_t push_data, q_head;

  // configuration is never back-pressured
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_cos      <= vrpd_pkg::RstRotCos;
      cfg_q.rot_sin      <= vrpd_pkg::RstRotSin;
      cfg_q.depth_offset <= vrpd_pkg::RstDepthOf;
      cfg_q.proj_scale_x <= vrpd_pkg::RstScale;
      cfg_q.proj_scale_y <= vrpd_pkg::RstScale;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vrpd_pkg::CFG_ROT_COS:      cfg_q.rot_cos      <= cfg_data_i[RW-1:0];
        vrpd_pkg::CFG_ROT_SIN:      cfg_q.rot_sin      <= cfg_data_i[RW-1:0];
        vrpd_pkg::CFG_DEPTH_OFFSET: cfg_q.depth_offset <= cfg_data_i;
        vrpd_pkg::CFG_PROJ_SCALE_X: cfg_q.proj_scale_x <= cfg_data_i[RW-1:0];
        vrpd_pkg::CFG_PROJ_SCALE_Y: cfg_q.proj_scale_y <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // rotation, offset and projection products
  vrpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples the front from output stalls
  vrpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // perspective divide and output register
  vrpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // a vertex behind the eye never carries screen coordinates
  `VRPD_ASSERT_NOW(a_invalid_zero, out_valid_o && out_o.depth_invalid,
                   out_o.screen_x == '0 && out_o.screen_y == '0,
                   "invalid depth with nonzero screen coordinates")

endmodule

// File: src/vrpd_front.sv
// front end: rotation about y, x, z, depth offset, classification and projection products
module vrpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrpd_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vrpd_pkg::vertex_t in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output vrpd_pkg::proj_t   push_data_o
);

  localparam int CW   = vrpd_pkg::COORD_WIDTH;
  localparam int PW   = vrpd_pkg::ProdW;
  localparam int SumW = PW + 1;
  localparam int QW   = SumW + 1 - 14;
  localparam int NS   = 8;

  localparam logic [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [PW-1:0] uc;
    logic signed [PW-1:0] us;
    logic signed [PW-1:0] vc;
    logic signed [PW-1:0] vs;
    logic signed [CW-1:0] keep;
    logic                 last;
  } prod_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 bad;
    logic                 last;
  } rot_t;

  // round to nearest q8.16 (ties up) and saturate
  function automatic logic signed [CW-1:0] round_sat(input logic signed [SumW-1:0] v);
    logic signed [SumW:0] w;
    logic [QW-1:0]        q;
    logic [QW-CW:0]       upper;
    w     = (SumW+1)'(v) + (SumW+1)'(8192);
    q     = w[SumW:14];
    upper = q[QW-1:CW-1];
    if ((&upper) || !(|upper)) begin
      round_sat = q[CW-1:0];
    end else begin
      round_sat = upper[QW-CW] ? CMin : CMax;
    end
  endfunction

  logic [NS-1:0] vld_q;
  logic          en;
  prod_t         p1_q, p3_q, p5_q, p1_d, p3_d, p5_d;
  rot_t          r2_q, r4_q, r6_q, r7_q, r2_d, r4_d, r6_d, r7_d;
  vrpd_pkg::proj_t pj_q, pj_d;
  logic signed [CW:0] zsum;

  assign en         = !(vld_q[NS-1] && q_full_i);
  assign in_ready_o = en;
  assign push_o     = vld_q[NS-1] && !q_full_i;
  assign push_data_o = pj_q;

  always_comb begin
    // about y: u = x, v = z
    p1_d.uc   = in_i.vertex_x * cfg_i.rot_cos;
    p1_d.us   = in_i.vertex_x * cfg_i.rot_sin;
    p1_d.vc   = in_i.vertex_z * cfg_i.rot_cos;
    p1_d.vs   = in_i.vertex_z * cfg_i.rot_sin;
    p1_d.keep = in_i.vertex_y;
    p1_d.last = in_i.last_vertex;

    r2_d.x    = round_sat(SumW'(p1_q.uc) + SumW'(p1_q.vs));
    r2_d.z    = round_sat(SumW'(p1_q.vc) - SumW'(p1_q.us));
    r2_d.y    = p1_q.keep;
    r2_d.bad  = 1'b0;
    r2_d.last = p1_q.last;

    // about x: u = y, v = z
    p3_d.uc   = r2_q.y * cfg_i.rot_cos;
    p3_d.us   = r2_q.y * cfg_i.rot_sin;
    p3_d.vc   = r2_q.z * cfg_i.rot_cos;
    p3_d.vs   = r2_q.z * cfg_i.rot_sin;
    p3_d.keep = r2_q.x;
    p3_d.last = r2_q.last;

    r4_d.y    = round_sat(SumW'(p3_q.uc) - SumW'(p3_q.vs));
    r4_d.z    = round_sat(SumW'(p3_q.us) + SumW'(p3_q.vc));
    r4_d.x    = p3_q.keep;
    r4_d.bad  = 1'b0;
    r4_d.last = p3_q.last;

    // about z: u = x, v = y
    p5_d.uc   = r4_q.x * cfg_i.rot_cos;
    p5_d.us   = r4_q.x * cfg_i.rot_sin;
    p5_d.vc   = r4_q.y * cfg_i.rot_cos;
    p5_d.vs   = r4_q.y * cfg_i.rot_sin;
    p5_d.keep = r4_q.z;
    p5_d.last = r4_q.last;

    r6_d.x    = round_sat(SumW'(p5_q.uc) - SumW'(p5_q.vs));
    r6_d.y    = round_sat(SumW'(p5_q.us) + SumW'(p5_q.vc));
    r6_d.z    = p5_q.keep;
    r6_d.bad  = 1'b0;
    r6_d.last = p5_q.last;

    // depth offset with saturation, then classify
    zsum = (CW+1)'(r6_q.z) + (CW+1)'(cfg_i.depth_offset);
    r7_d = r6_q;
    if (zsum[CW] == zsum[CW-1]) begin
      r7_d.z = zsum[CW-1:0];
    end else begin
      r7_d.z = zsum[CW] ? CMin : CMax;
    end
    r7_d.bad = r7_d.z[CW-1] || (r7_d.z == '0);

    pj_d.num_x = r7_q.x * $signed({1'b0, cfg_i.proj_scale_x});
    pj_d.num_y = r7_q.y * $signed({1'b0, cfg_i.proj_scale_y});
    pj_d.z     = r7_q.z;
    pj_d.bad   = r7_q.bad;
    pj_d.last  = r7_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      r2_q <= r2_d;
      p3_q <= p3_d;
      r4_q <= r4_d;
      p5_q <= p5_d;
      r6_q <= r6_d;
      r7_q <= r7_d;
      pj_q <= pj_d;
    end
  end

endmodule

// File: src/vrpd_queue.sv
// short queue of projected vertices between front and back
`include "vertex_rotate_project_divide_top_macros.svh"

module vrpd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vrpd_pkg::proj_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vrpd_pkg::proj_t head_o
);

  localparam int PtrW = vrpd_pkg::QPtrW;

  vrpd_pkg::proj_t entry_q [vrpd_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(vrpd_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= push_data_i;
  end

  `VRPD_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `VRPD_ASSERT_NOW(a_no_underflow, pop_i, valid_o, "pop from empty queue")
  `VRPD_ASSERT_NEXT(a_count_hold, push_i && pop_i, $stable(cnt_q), "count moved on push and pop")

endmodule

// File: src/vrpd_back.sv
// back end: pipelined restoring division of both projected coordinates by depth
module vrpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  vrpd_pkg::proj_t   q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrpd_pkg::screen_t out_o
);

  localparam int CW   = vrpd_pkg::COORD_WIDTH;
  localparam int NW   = vrpd_pkg::NumW;
  localparam int DW   = NW + 2;
  localparam int HiW  = DW - CW;
  localparam int CmpW = (HiW > CW) ? HiW : CW;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] sh;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t                lx;
    lane_t                ly;
    logic signed [CW-1:0] z;
    logic                 bad;
    logic                 last;
  } div_t;

  function automatic lane_t lane_prep(input logic signed [NW-1:0] num,
                                      input logic [CW-1:0] z);
    lane_t         l;
    logic [NW-1:0] mag;
    logic [DW-1:0] dvd;
    logic [HiW-1:0] hi;
    mag    = num[NW-1] ? NW'(-num) : NW'(num);
    dvd    = {mag, 2'b00};
    hi     = dvd[DW-1:CW];
    l.neg  = num[NW-1];
    l.ovf  = CmpW'(hi) >= CmpW'(z);
    l.rem  = CW'(hi);
    l.sh   = dvd[CW-1:0];
    return l;
  endfunction

  // one quotient bit
  function automatic lane_t lane_step(input lane_t l, input logic [CW-1:0] z);
    lane_t     n;
    logic [CW:0] t;
    logic      qb;
    t     = {l.rem, l.sh[CW-1]};
    qb    = (t >= {1'b0, z});
    n     = l;
    n.rem = qb ? CW'(t - {1'b0, z}) : CW'(t);
    n.sh  = {l.sh[CW-2:0], qb};
    return n;
  endfunction

  function automatic logic [CW-1:0] lane_final(input lane_t l);
    logic [CW-1:0] lim;
    logic [CW-1:0] q;
    lim = l.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    q   = (l.ovf || (l.sh > lim)) ? lim : l.sh;
    return l.neg ? CW'(-q) : q;
  endfunction

  div_t              st_q [CW+1];
  div_t              st_d [CW+1];
  logic [CW:0]       vld_q;
  logic              en;
  div_t              prep;
  vrpd_pkg::screen_t out_q, out_d;
  logic              out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    prep.lx   = lane_prep(q_head_i.num_x, q_head_i.z);
    prep.ly   = lane_prep(q_head_i.num_y, q_head_i.z);
    prep.z    = q_head_i.z;
    prep.bad  = q_head_i.bad;
    prep.last = q_head_i.last;

    st_d[0] = prep;
    for (int k = 1; k <= CW; k++) begin
      st_d[k]    = st_q[k-1];
      st_d[k].lx = lane_step(st_q[k-1].lx, st_q[k-1].z);
      st_d[k].ly = lane_step(st_q[k-1].ly, st_q[k-1].z);
    end

    out_d.screen_x      = st_q[CW].bad ? '0 : lane_final(st_q[CW].lx);
    out_d.screen_y      = st_q[CW].bad ? '0 : lane_final(st_q[CW].ly);
    out_d.depth         = st_q[CW].z;
    out_d.depth_invalid = st_q[CW].bad;
    out_d.last_out      = st_q[CW].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[CW-1:0], q_valid_i};
      out_valid_q <= vld_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= CW; k++) begin
        st_q[k] <= st_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule
